// File: sv/ihex_pkg.sv
package ihex_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned PosWidth   = 10;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned AddrWidth  = 16;
   localparam int unsigned KWidth     = 9;

   localparam logic [PosWidth-1:0]  PosMax       = 10'd1023;
   localparam logic [PosWidth-1:0]  LineOverhead = 10'd11;
   localparam logic [PosWidth-1:0]  HeaderChars  = 10'd3;
   localparam logic [KWidth-1:0]    HeaderBytes  = 9'd4;
   localparam logic [ByteWidth-1:0] EndRecType   = 8'h01;
   localparam logic [AddrWidth-1:0] EndRecAddr   = 16'h0000;

   localparam logic [CharWidth-1:0] CharColon = 8'h3A;
   localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
   localparam logic [CharWidth-1:0] CharLf    = 8'h0A;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_RECORD    = 2'd1,
      KIND_LOAD_OK   = 2'd2,
      KIND_LOAD_FAIL = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      FAIL_NONE       = 3'd0,
      FAIL_NO_COLON   = 3'd1,
      FAIL_BAD_HEX    = 3'd2,
      FAIL_LENGTH     = 3'd3,
      FAIL_CHECKSUM   = 3'd4,
      FAIL_NO_RECORDS = 3'd5,
      FAIL_NO_END     = 3'd6,
      FAIL_STRAY_CR   = 3'd7
   } fail_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 end_of_input;
   } item_type;

   typedef struct packed {
      kind_type             kind;
      logic [AddrWidth-1:0] address;
      logic [ByteWidth-1:0] rtype;
      logic [ByteWidth-1:0] value;
      logic [ByteWidth-1:0] index;
      logic [ByteWidth-1:0] count;
      fail_type             code;
   } result_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [CharWidth-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      case (c) inside
         [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
         [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
         [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
         default:       r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// File: sv/ihex_in_stage.sv
module ihex_in_stage
   import ihex_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     fire,
   output logic     in_valid,
   output item_type in_item
);

   logic     vld_ff, vld_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = vld_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (fire) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign in_valid = vld_ff;
   assign in_item  = item_ff;

endmodule

// File: sv/ihex_core.sv
module ihex_core
   import ihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic [ByteWidth-1:0] count_ff, count_in;
   logic [AddrWidth-1:0] addr_ff, addr_in;
   logic [ByteWidth-1:0] type_ff, type_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [3:0]           hi_ff, hi_in;
   logic                 pcr_ff, pcr_in;
   logic                 failed_ff, failed_in;
   logic                 seen_ff, seen_in;
   logic                 lastend_ff, lastend_in;

   logic [4:0]           hex;
   logic [PosWidth-1:0]  target;
   logic [PosWidth-1:0]  pos_m2;
   logic [KWidth-1:0]    k;
   logic [KWidth-1:0]    k_data;
   logic [KWidth-1:0]    k_limit;
   logic [ByteWidth-1:0] b;
   fail_type             fin_code;
   logic                 fin_end;
   logic                 seen_v, last_v, fin_fail;

   assign hex     = hex_decode(item.char_code);
   assign target  = LineOverhead + {1'b0, count_ff, 1'b0};
   assign pos_m2  = pos_ff - 10'd2;
   assign k       = pos_m2[PosWidth-1:1];
   assign k_data  = k - HeaderBytes;
   assign k_limit = HeaderBytes + {1'b0, count_ff};
   assign b       = {hi_ff, hex[3:0]};
   assign fin_end = (addr_ff == EndRecAddr) && (count_ff == '0) && (type_ff == EndRecType);

   always_comb begin
      if (pos_ff == '0) begin
         fin_code = FAIL_NO_COLON;
      end else if (pos_ff != target) begin
         fin_code = FAIL_LENGTH;
      end else if (sum_ff != '0) begin
         fin_code = FAIL_CHECKSUM;
      end else begin
         fin_code = FAIL_NONE;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      type_in    = type_ff;
      sum_in     = sum_ff;
      hi_in      = hi_ff;
      pcr_in     = pcr_ff;
      failed_in  = failed_ff;
      seen_in    = seen_ff;
      lastend_in = lastend_ff;
      seen_v     = seen_ff;
      last_v     = lastend_ff;
      fin_fail   = 1'b0;
      res_valid  = 1'b0;
      res.kind    = KIND_DATA;
      res.address = addr_ff;
      res.rtype   = type_ff;
      res.value   = '0;
      res.index   = '0;
      res.count   = count_ff;
      res.code    = FAIL_NONE;

      if (fire && !failed_ff) begin
         if (item.end_of_input) begin
            // unterminated last line
            if (pos_ff != '0 || pcr_ff) begin
               if (fin_code != FAIL_NONE) begin
                  fin_fail = 1'b1;
               end else begin
                  seen_v = 1'b1;
                  last_v = fin_end;
               end
               pos_in = '0;
               sum_in = '0;
               hi_in  = '0;
               pcr_in = 1'b0;
            end
            seen_in    = seen_v;
            lastend_in = last_v;
            res_valid  = 1'b1;
            if (fin_fail) begin
               res.kind  = KIND_LOAD_FAIL;
               res.code  = fin_code;
               failed_in = 1'b1;
            end else if (!seen_v) begin
               res.kind  = KIND_LOAD_FAIL;
               res.code  = FAIL_NO_RECORDS;
               failed_in = 1'b1;
            end else if (!last_v) begin
               res.kind  = KIND_LOAD_FAIL;
               res.code  = FAIL_NO_END;
               failed_in = 1'b1;
            end else begin
               res.kind   = KIND_LOAD_OK;
               pos_in     = '0;
               count_in   = '0;
               addr_in    = '0;
               type_in    = '0;
               sum_in     = '0;
               hi_in      = '0;
               pcr_in     = 1'b0;
               seen_in    = 1'b0;
               lastend_in = 1'b0;
            end
         end else if (pcr_ff && item.char_code != CharLf) begin
            res_valid = 1'b1;
            res.kind  = KIND_LOAD_FAIL;
            res.code  = FAIL_STRAY_CR;
            failed_in = 1'b1;
         end else if (item.char_code == CharCr) begin
            pcr_in = 1'b1;
         end else if (item.char_code == CharLf) begin
            pos_in    = '0;
            sum_in    = '0;
            hi_in     = '0;
            pcr_in    = 1'b0;
            res_valid = 1'b1;
            if (fin_code != FAIL_NONE) begin
               res.kind  = KIND_LOAD_FAIL;
               res.code  = fin_code;
               failed_in = 1'b1;
            end else begin
               res.kind   = KIND_RECORD;
               seen_in    = 1'b1;
               lastend_in = fin_end;
            end
         end else begin
            if (pos_ff < PosMax) begin
               pos_in = pos_ff + 10'd1;
            end
            if (pos_ff == '0) begin
               if (item.char_code != CharColon) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_LOAD_FAIL;
                  res.code  = FAIL_NO_COLON;
                  failed_in = 1'b1;
               end
            end else if (!hex[4]) begin
               res_valid = 1'b1;
               res.kind  = KIND_LOAD_FAIL;
               res.code  = FAIL_BAD_HEX;
               failed_in = 1'b1;
            end else if (pos_ff >= HeaderChars && pos_ff >= target) begin
               res_valid = 1'b1;
               res.kind  = KIND_LOAD_FAIL;
               res.code  = FAIL_LENGTH;
               failed_in = 1'b1;
            end else if (pos_ff[0]) begin
               hi_in = hex[3:0];
            end else begin
               sum_in = sum_ff + b;
               case (k)
                  9'd0:    count_in = b;
                  9'd1:    addr_in  = {b, addr_ff[7:0]};
                  9'd2:    addr_in  = {addr_ff[15:8], b};
                  9'd3:    type_in  = b;
                  default: begin
                     if (k < k_limit) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_DATA;
                        res.value = b;
                        res.index = k_data[ByteWidth-1:0];
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         count_ff   <= '0;
         addr_ff    <= '0;
         type_ff    <= '0;
         sum_ff     <= '0;
         hi_ff      <= '0;
         pcr_ff     <= 1'b0;
         failed_ff  <= 1'b0;
         seen_ff    <= 1'b0;
         lastend_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         addr_ff    <= addr_in;
         type_ff    <= type_in;
         sum_ff     <= sum_in;
         hi_ff      <= hi_in;
         pcr_ff     <= pcr_in;
         failed_ff  <= failed_in;
         seen_ff    <= seen_in;
         lastend_ff <= lastend_in;
      end
   end

endmodule

// File: sv/ihex_out_stage.sv
module ihex_out_stage
   import ihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       res_valid,
   input  result_type res,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_res
);

   logic       vld_ff, vld_in;
   result_type res_ff;
   logic       load;

   assign out_free = !vld_ff || !rsp_stall;
   assign load     = fire && res_valid;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_res   = res_ff;

endmodule

// File: sv/intel_hex_record_parser.sv
// Intel HEX record parser
// input channel: one ASCII character per beat on req_char_code, or an end of text
// marker on req_end_of_input; handshake is req_valid / req_stall
// result channel: at most one beat per input beat on the rsp_ ports, handshake
// rsp_valid / rsp_stall: data bytes as they are parsed, record complete at each
// LF, load ok or load failed at end of text, or load failed at the first error
// a character accepted into the input register is parsed and its result is loaded
// into the result register; one character enters every cycle while results drain
// throughput is set by the single parse step between the input register and
// the result register
// after a failure every further beat is taken and gives no result until reset
// after load ok the parser is back in its reset state, ready for a new text
// reset (synchronous, active high) clears the parser state and both stages
// when rsp_stall is high the held result stays put; the input register still
// fills, and only then does req_stall rise
module intel_hex_record_parser
   import ihex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_record_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_data_value,
   output logic [7:0]  rsp_data_index,
   output logic [7:0]  rsp_byte_count,
   output logic [2:0]  rsp_failure_code
);

   item_type   req_item, in_item;
   logic       in_valid, out_free, fire, res_valid;
   result_type res, rsp_res;

   assign req_item.char_code    = req_char_code;
   assign req_item.end_of_input = req_end_of_input;
   assign fire = in_valid && out_free;

   ihex_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .fire      (fire),
      .in_valid  (in_valid),
      .in_item   (in_item)
   );

   ihex_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item),
      .res_valid (res_valid),
      .res       (res)
   );

   ihex_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (rsp_res)
   );

   assign rsp_result_kind    = rsp_res.kind;
   assign rsp_record_address = rsp_res.address;
   assign rsp_record_type    = rsp_res.rtype;
   assign rsp_data_value     = rsp_res.value;
   assign rsp_data_index     = rsp_res.index;
   assign rsp_byte_count     = rsp_res.count;
   assign rsp_failure_code   = rsp_res.code;

endmodule

// File: sv/ihex_checker.sv
module ihex_checker
   import ihex_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [7:0]  rsp_data_value,
   input logic [7:0]  rsp_data_index,
   input logic [7:0]  rsp_byte_count,
   input logic [2:0]  rsp_failure_code
);

   // held beat keeps its kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_LOAD_FAIL |-> rsp_failure_code == FAIL_NONE)
      else $error("failure code on a non-failure beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_DATA |-> rsp_data_index < rsp_byte_count)
      else $error("data index beyond byte count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_DATA |->
         rsp_data_value == 8'd0 && rsp_data_index == 8'd0)
      else $error("data fields set on a non-data beat");

   // failure is sticky
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_result_kind == KIND_LOAD_FAIL |=> !rsp_valid)
      else $error("result after a failure");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_data_value   (rsp_data_value),
   .rsp_data_index   (rsp_data_index),
   .rsp_byte_count   (rsp_byte_count),
   .rsp_failure_code (rsp_failure_code)
);

// File: sim/intel_hex_record_parser_checker.sv
`timescale 1ns / 100ps

module intel_hex_record_parser_checker
   import ihex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_result_kind,
   input  logic [15:0] rsp_record_address,
   input  logic [7:0]  rsp_record_type,
   input  logic [7:0]  rsp_data_value,
   input  logic [7:0]  rsp_data_index,
   input  logic [7:0]  rsp_byte_count,
   input  logic [2:0]  rsp_failure_code,
   output int          error_count,
   output int          results_due
);

   localparam int ReportLimit = 10;

   result_type expected_results[$];

   logic [PosWidth-1:0]  line_pos;
   logic [ByteWidth-1:0] rec_count;
   logic [AddrWidth-1:0] rec_addr;
   logic [ByteWidth-1:0] rec_type;
   logic [ByteWidth-1:0] line_sum;
   logic [3:0]           upper_nibble;
   logic                 cr_held;
   logic                 stream_failed;
   logic                 record_seen;
   logic                 last_was_eof;

   task automatic clear_parse();
      line_pos      = '0;
      rec_count     = '0;
      rec_addr      = '0;
      rec_type      = '0;
      line_sum      = '0;
      upper_nibble  = '0;
      cr_held       = 1'b0;
      stream_failed = 1'b0;
      record_seen   = 1'b0;
      last_was_eof  = 1'b0;
   endtask

   function automatic int nibble_of(input logic [7:0] c);
      int v;
      v = int'(c);
      if (v >= 'h30 && v <= 'h39) return v - 'h30;
      if (v >= 'h41 && v <= 'h46) return v - 'h41 + 10;
      if (v >= 'h61 && v <= 'h66) return v - 'h61 + 10;
      return -1;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("kind %0d address %h type %h value %h index %0d count %0d code %0d",
                       r.kind, r.address, r.rtype, r.value, r.index, r.count, r.code);
   endfunction

   task automatic post(input kind_type k, input logic [7:0] v, input logic [7:0] idx,
                       input fail_type f);
      result_type r;
      r.kind    = k;
      r.address = rec_addr;
      r.rtype   = rec_type;
      r.value   = v;
      r.index   = idx;
      r.count   = rec_count;
      r.code    = f;
      expected_results.push_back(r);
   endtask

   task automatic post_failure(input fail_type f);
      stream_failed = 1'b1;
      post(KIND_LOAD_FAIL, '0, '0, f);
   endtask

   function automatic fail_type close_line();
      fail_type code;
      code = FAIL_NONE;
      if (line_pos == '0)
         code = FAIL_NO_COLON;
      else if (int'(line_pos) != int'(LineOverhead) + 2 * int'(rec_count))
         code = FAIL_LENGTH;
      else if (line_sum != '0)
         code = FAIL_CHECKSUM;
      if (code == FAIL_NONE) begin
         record_seen  = 1'b1;
         last_was_eof = (rec_addr == EndRecAddr) && (rec_count == '0) &&
                        (rec_type == EndRecType);
      end
      line_pos     = '0;
      line_sum     = '0;
      upper_nibble = '0;
      cr_held      = 1'b0;
      return code;
   endfunction

   task automatic predict_beat(input logic [7:0] ch, input logic eot);
      fail_type   code;
      int         p;
      int         nib;
      int         k;
      int         lim;
      logic [7:0] b;
      if (stream_failed) return;
      if (eot) begin
         if (line_pos != '0 || cr_held) begin
            code = close_line();
            if (code != FAIL_NONE) begin
               post_failure(code);
               return;
            end
         end
         if (!record_seen) begin
            post_failure(FAIL_NO_RECORDS);
         end else if (!last_was_eof) begin
            post_failure(FAIL_NO_END);
         end else begin
            post(KIND_LOAD_OK, '0, '0, FAIL_NONE);
            clear_parse();
         end
         return;
      end
      if (cr_held && ch != CharLf) begin
         post_failure(FAIL_STRAY_CR);
         return;
      end
      if (ch == CharCr) begin
         cr_held = 1'b1;
         return;
      end
      if (ch == CharLf) begin
         code = close_line();
         if (code != FAIL_NONE) post_failure(code);
         else post(KIND_RECORD, '0, '0, FAIL_NONE);
         return;
      end
      p = int'(line_pos);
      if (line_pos != PosMax) line_pos = line_pos + 1'b1;
      if (p == 0) begin
         if (ch != CharColon) post_failure(FAIL_NO_COLON);
         return;
      end
      nib = nibble_of(ch);
      lim = int'(LineOverhead) + 2 * int'(rec_count);
      if (nib < 0) begin
         post_failure(FAIL_BAD_HEX);
      end else if (p >= int'(HeaderChars) && p >= lim) begin
         post_failure(FAIL_LENGTH);
      end else if (p % 2 == 1) begin
         upper_nibble = 4'(nib);
      end else begin
         b = {upper_nibble, 4'(nib)};
         k = (p - 2) / 2;
         line_sum = line_sum + b;
         case (k)
            0: rec_count = b;
            1: rec_addr[15:8] = b;
            2: rec_addr[7:0] = b;
            3: rec_type = b;
            default: begin
               if (k < int'(HeaderBytes) + int'(rec_count))
                  post(KIND_DATA, b, 8'(k - int'(HeaderBytes)), FAIL_NONE);
            end
         endcase
      end
   endtask

   task automatic take_result();
      result_type got;
      result_type want;
      got.kind    = kind_type'(rsp_result_kind);
      got.address = rsp_record_address;
      got.rtype   = rsp_record_type;
      got.value   = rsp_data_value;
      got.index   = rsp_data_index;
      got.count   = rsp_byte_count;
      got.code    = fail_type'(rsp_failure_code);
      if (expected_results.size() == 0) begin
         if (error_count < ReportLimit) $display("unexpected result beat: %s", describe(got));
         error_count++;
      end else begin
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.address !== want.address ||
             got.rtype !== want.rtype || got.value !== want.value ||
             got.index !== want.index || got.count !== want.count ||
             got.code !== want.code) begin
            if (error_count < ReportLimit) begin
               $display("result mismatch");
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) take_result();
         if (req_valid && !req_stall) predict_beat(req_char_code, req_end_of_input);
      end
      results_due = expected_results.size();
   end

endmodule

// File: sim/tb_intel_hex_record_parser.sv
`timescale 1ns / 100ps

module tb_intel_hex_record_parser
   import ihex_pkg::*;
();

   localparam int CycleLimit    = 200000;
   localparam int PhaseBeats    = 60;
   localparam int StretchCycles = 400;
   localparam int NoiseBeats    = 30;
   localparam int LargestCount  = 255;

   localparam logic [7:0] AsciiZero   = 8'h30;
   localparam logic [7:0] AsciiUpperA = 8'h41;
   localparam logic [7:0] AsciiLowerA = 8'h61;
   localparam logic [7:0] DataRecType = 8'h00;

   typedef enum {FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_SUM} flaw_type;
   typedef enum {
      TAIL_NO_COLON, TAIL_EMPTY_LINE, TAIL_BAD_HEX, TAIL_OVERLONG, TAIL_SHORT,
      TAIL_CHECKSUM, TAIL_NO_RECORDS, TAIL_NO_END, TAIL_STRAY_CR, TAIL_LONE_CR
   } tail_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_record_address;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_data_value;
   logic [7:0]  rsp_data_index;
   logic [7:0]  rsp_byte_count;
   logic [2:0]  rsp_failure_code;

   int  mismatch_total;
   int  results_due;
   int  tx_idle_pct;
   int  rx_idle_pct;
   int  beats_sent;
   int  cycle_count;
   bit  stretch_hold;

   item_type text_q[$];

   intel_hex_record_parser dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_record_address (rsp_record_address),
      .rsp_record_type    (rsp_record_type),
      .rsp_data_value     (rsp_data_value),
      .rsp_data_index     (rsp_data_index),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_failure_code   (rsp_failure_code)
   );

   intel_hex_record_parser_checker parse_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_end_of_input   (req_end_of_input),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_record_address (rsp_record_address),
      .rsp_record_type    (rsp_record_type),
      .rsp_data_value     (rsp_data_value),
      .rsp_data_index     (rsp_data_index),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_failure_code   (rsp_failure_code),
      .error_count        (mismatch_total),
      .results_due        (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic put_char(input logic [7:0] c);
      item_type it;
      it.char_code    = c;
      it.end_of_input = 1'b0;
      text_q.push_back(it);
   endtask

   task automatic put_eot();
      item_type it;
      it.char_code    = 8'($urandom);
      it.end_of_input = 1'b1;
      text_q.push_back(it);
   endtask

   task automatic put_string(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   task automatic put_eol();
      if ($urandom_range(1)) put_char(CharCr);
      put_char(CharLf);
   endtask

   task automatic put_hex_digit(input logic [3:0] n);
      logic [7:0] c;
      if (n < 10) c = AsciiZero + n;
      else if ($urandom_range(1)) c = 8'(AsciiUpperA + n - 8'd10);
      else c = 8'(AsciiLowerA + n - 8'd10);
      put_char(c);
   endtask

   task automatic put_hex_byte(input logic [7:0] b);
      put_hex_digit(b[7:4]);
      put_hex_digit(b[3:0]);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_count();
      return ($urandom_range(3) == 0) ? 0 : int'($urandom_range(1, 16));
   endfunction

   task automatic put_record(input int cnt, input logic [15:0] addr, input logic [7:0] rtype,
                             input flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      put_char(CharColon);
      sum = 8'(cnt) + addr[15:8] + addr[7:0] + rtype;
      put_hex_byte(8'(cnt));
      put_hex_byte(addr[15:8]);
      put_hex_byte(addr[7:0]);
      put_hex_byte(rtype);
      for (i = 0; i < cnt; i++) begin
         b = pick_byte();
         sum = sum + b;
         put_hex_byte(b);
      end
      b = 8'h00 - sum;
      case (flaw)
         FLAW_SUM: put_hex_byte(b + 8'($urandom_range(1, 255)));
         FLAW_SHORT: begin
            if ($urandom_range(1)) put_hex_digit(b[7:4]);
         end
         FLAW_LONG: begin
            put_hex_byte(b);
            put_hex_digit(4'($urandom));
         end
         default: put_hex_byte(b);
      endcase
   endtask

   task automatic put_random_record(input int cnt);
      logic [15:0] addr;
      logic [7:0]  rtype;
      if ($urandom_range(3) == 0) addr = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      else addr = 16'($urandom);
      rtype = $urandom_range(1) ? 8'($urandom_range(5)) : 8'($urandom);
      put_record(cnt, addr, rtype, FLAW_NONE);
      put_eol();
   endtask

   task automatic put_good_text(input bit with_largest);
      int n;
      int i;
      n = $urandom_range(3);
      if (with_largest && n == 0) n = 1;
      for (i = 0; i < n; i++)
         put_random_record((with_largest && i == 0) ? LargestCount : pick_count());
      put_record(0, EndRecAddr, EndRecType, FLAW_NONE);
      n = $urandom_range(3);
      if (n == 1) put_char(CharCr);
      else if (n > 1) put_eol();
      put_eot();
   endtask

   task automatic put_bad_tail();
      tail_type   tail;
      logic [7:0] c;
      int         i;
      tail = tail_type'($urandom_range(int'(TAIL_LONE_CR)));
      if (tail != TAIL_NO_RECORDS)
         for (i = $urandom_range(2); i > 0; i--) put_random_record(pick_count());
      case (tail)
         TAIL_NO_COLON: begin
            c = 8'($urandom);
            if (c == CharColon || c == CharCr || c == CharLf) c[7] = 1'b1;
            put_char(c);
            put_eol();
         end
         TAIL_EMPTY_LINE: put_eol();
         TAIL_BAD_HEX: begin
            put_char(CharColon);
            for (i = $urandom_range(9); i > 0; i--) put_hex_digit(4'($urandom));
            c = 8'($urandom);
            if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66], CharCr, CharLf})
               c[7] = 1'b1;
            put_char(c);
         end
         TAIL_OVERLONG: put_record(pick_count(), 16'($urandom), 8'($urandom), FLAW_LONG);
         TAIL_SHORT: begin
            put_record(pick_count(), 16'($urandom), 8'($urandom), FLAW_SHORT);
            put_eol();
         end
         TAIL_CHECKSUM: begin
            put_record(pick_count(), 16'($urandom), 8'($urandom), FLAW_SUM);
            put_eol();
         end
         TAIL_NO_END: begin
            case ($urandom_range(2))
               0: put_record(pick_count(), 16'($urandom), DataRecType, FLAW_NONE);
               1: put_record(0, 16'($urandom_range(1, 16'hFFFF)), EndRecType, FLAW_NONE);
               default: put_record(1, EndRecAddr, EndRecType, FLAW_NONE);
            endcase
            put_eol();
            put_eot();
         end
         TAIL_STRAY_CR: begin
            put_char(CharColon);
            for (i = $urandom_range(6); i > 0; i--) put_hex_digit(4'($urandom));
            put_char(CharCr);
            c = 8'($urandom);
            if (c == CharLf) c[7] = 1'b1;
            put_char(c);
         end
         TAIL_LONE_CR: begin
            put_char(CharCr);
            put_eot();
         end
         default: put_eot();
      endcase
   endtask

   task automatic send_beat(input item_type it);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= it.char_code;
      req_end_of_input <= it.end_of_input;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text();
      while (text_q.size() > 0) send_beat(text_q.pop_front());
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_due == 0);
      @(posedge clock);
   endtask

   // receiver side stall pattern
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_hold) begin
            stretch_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (StretchCycles) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_code    = '0;
      req_end_of_input = 1'b0;
      stretch_hold     = 1'b0;
      tx_idle_pct      = 6;
      rx_idle_pct      = 69;
      beats_sent       = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all-ones fields, cr-lf, unterminated end record behind a dropped cr
      put_string(":01FFFFFFFF03");
      put_char(CharCr);
      put_char(CharLf);
      put_string(":00000001ff");
      put_char(CharCr);
      put_eot();
      send_text();

      while (beats_sent < PhaseBeats) begin
         put_good_text(1'b0);
         send_text();
      end
      pause_until_drained();

      tx_idle_pct = 69;
      rx_idle_pct = 6;
      while (beats_sent < 2 * PhaseBeats) begin
         put_good_text(1'b0);
         send_text();
      end
      pause_until_drained();

      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      stretch_hold = 1'b1;
      put_good_text(1'b1);
      send_text();

      // sticky failure ends the run, then beats that must be ignored
      put_bad_tail();
      for (i = 0; i < NoiseBeats; i++) begin
         if ($urandom_range(7) == 0) put_eot();
         else put_char(8'($urandom));
      end
      send_text();

      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_due == 0);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0 && results_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/ihex_pkg.sv
sv/ihex_in_stage.sv
sv/ihex_core.sv
sv/ihex_out_stage.sv
sv/intel_hex_record_parser.sv
sv/ihex_checker.sv
sim/intel_hex_record_parser_checker.sv
sim/tb_intel_hex_record_parser.sv
